// File: rtl/shared_buffer_multi_queue_defines.svh
// Assertion macros shared by the shared-buffer multi-queue RTL.
`ifndef SHARED_BUFFER_MULTI_QUEUE_DEFINES_SVH
`define SHARED_BUFFER_MULTI_QUEUE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SBMQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SBMQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sbmq_pkg.sv
// Types and codes of the shared-buffer multi-queue.
package sbmq_pkg;

  localparam int DataW = 32;
  localparam int QselW = 2;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic                     command;
    logic [QselW-1:0]         queue_select;
    logic signed [DataW-1:0]  item_value;
  } request_t;

  typedef struct packed {
    status_t                  status;
    logic signed [DataW-1:0]  removed_value;
    logic signed [DataW-1:0]  front_value;
    logic                     queue_empty;
  } result_t;

endpackage

// File: rtl/shared_buffer_multi_queue.sv
// Shared-buffer multi-queue: QUEUES FIFOs chained through one slot store.
//
// A request transfers at every rising edge with start high; busy stays low,
// so one request may follow another in every cycle. Each request gives
// exactly one result, shown on result for one cycle with done high. The
// edge that takes the request loads the request register; from that
// register the queue state is updated, and the result register and done
// are loaded together.
// The receiver cannot stall, so results must be taken as they
// come. An enqueue pops the top of the free-slot stack, writes the value
// there and links the slot after the queue's tail; with no free slot it
// reports overflow and changes nothing. A dequeue unlinks the queue's head
// slot and pushes it back on the free stack; on an empty queue it reports
// underflow. Every result also carries the addressed queue's new front
// value and an empty flag. A queue number at or above QUEUES is a queue
// that is always empty and accepts nothing. Slot links, heads, tails and
// the free stack are ready right out of reset; no clearing pass is needed.
module shared_buffer_multi_queue
  import sbmq_pkg::*;
#(
  parameter int SLOTS  = 16,
  parameter int QUEUES = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output logic     done,
  output result_t  result
);

  `include "shared_buffer_multi_queue_defines.svh"

  // Slot index width, link width (one extra code for null), queue index width.
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LW = $clog2(SLOTS + 1);
  localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam logic [LW-1:0] NIL = LW'(SLOTS);

  // Request register.
  request_t req;
  logic     req_valid;

  // Queue state.
  logic [DataW-1:0] slot_data [SLOTS];
  logic [LW-1:0]    slot_link [SLOTS];
  logic [LW-1:0]    queue_head [QUEUES];
  logic [LW-1:0]    queue_tail [QUEUES];
  logic [LW-1:0]    free_top;

  // Decode of the registered request.
  logic          exists;
  logic [QW-1:0] qi;
  logic [LW-1:0] hd, tl, nx;
  logic          hd_ok, tl_ok, nx_ok, ft_ok;
  logic [SW-1:0] hd_i, tl_i, nx_i, ft_i;
  logic          do_enq, do_deq;
  result_t       result_next;

  // Never stall the requester: every request finishes in one pass.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start;
    end
  end

  // Hold payload without reset; only the valid flag matters.
  always_ff @(posedge clk) begin
    if (start) begin
      req <= request;
    end
  end

  // Look up the addressed queue: head, tail, head's successor, free top.
  always_comb begin
    exists = int'(req.queue_select) < QUEUES;
    qi     = QW'(req.queue_select);
    hd     = queue_head[qi];
    tl     = queue_tail[qi];
    hd_ok  = hd < NIL;
    tl_ok  = tl < NIL;
    ft_ok  = free_top < NIL;
    hd_i   = hd[SW-1:0];
    tl_i   = tl[SW-1:0];
    ft_i   = free_top[SW-1:0];
    nx     = slot_link[hd_i];
    nx_ok  = nx < NIL;
    nx_i   = nx[SW-1:0];
    do_enq = req_valid && exists && (req.command == CMD_ENQ) && ft_ok;
    do_deq = req_valid && exists && (req.command == CMD_DEQ) && hd_ok;
  end

  // Build the result: outcome, removed value and the queue's new front.
  always_comb begin
    result_next = '0;
    if (req.command == CMD_ENQ) begin
      result_next.status = (exists && ft_ok) ? ST_OK : ST_OVERFLOW;
    end else begin
      result_next.status = (exists && hd_ok) ? ST_OK : ST_UNDERFLOW;
    end
    if (do_deq) begin
      result_next.removed_value = slot_data[hd_i];
    end
    result_next.queue_empty = 1'b1;
    priority if (!exists) begin
      result_next.queue_empty = 1'b1;
    end else if (do_enq) begin
      // Front is the old head, or the new item on an empty queue.
      result_next.front_value = hd_ok ? slot_data[hd_i] : req.item_value;
      result_next.queue_empty = 1'b0;
    end else if (do_deq) begin
      // Front advances to the successor of the removed head.
      if (nx_ok) begin
        result_next.front_value = slot_data[nx_i];
        result_next.queue_empty = 1'b0;
      end
    end else if (hd_ok) begin
      // Failed operation: report the unchanged front.
      result_next.front_value = slot_data[hd_i];
      result_next.queue_empty = 1'b0;
    end else begin
      // Empty queue: no front to report.
      result_next.queue_empty = 1'b1;
    end
  end

  // Update links, heads, tails and the free stack.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_link[i] <= (i + 1 < SLOTS) ? LW'(i + 1) : NIL;
      end
      for (int i = 0; i < QUEUES; i++) begin
        queue_head[i] <= NIL;
        queue_tail[i] <= NIL;
      end
      free_top <= '0;
    end else begin
      if (do_enq) begin
        free_top <= slot_link[ft_i];
        if (!hd_ok) begin
          queue_head[qi] <= free_top;
        end else if (tl_ok) begin
          slot_link[tl_i] <= free_top;
        end
        slot_link[ft_i] <= NIL;
        queue_tail[qi]  <= free_top;
      end
      if (do_deq) begin
        if (nx_ok) begin
          queue_head[qi] <= nx;
        end else begin
          queue_head[qi] <= NIL;
          queue_tail[qi] <= NIL;
        end
        slot_link[hd_i] <= free_top;
        free_top        <= hd;
      end
    end
  end

  // Write the value into the popped slot; the store needs no reset.
  always_ff @(posedge clk) begin
    if (do_enq) begin
      slot_data[ft_i] <= req.item_value;
    end
  end

  // Result register and its one-cycle strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      result <= result_next;
    end
  end

  // Every registered request yields exactly one strobe on the next cycle.
  `SBMQ_ASSERT_NEXT(a_done_follows, req_valid, done, "request without result")
  `SBMQ_ASSERT_NEXT(a_no_extra_done, !req_valid, !done, "result without request")
  // A successful enqueue leaves its queue with a front.
  `SBMQ_ASSERT_NEXT(a_enq_nonempty, do_enq,
                    result.status == ST_OK && !result.queue_empty,
                    "enqueue left queue empty")
  // Only a successful dequeue removes a value; an empty queue has no front.
  `SBMQ_ASSERT_NOW(a_fail_no_removed, done && result.status != ST_OK,
                   result.removed_value == '0, "failed operation removed a value")
  `SBMQ_ASSERT_NOW(a_empty_no_front, done && result.queue_empty,
                   result.front_value == '0, "empty queue reports a front")
  // The free-stack top is a slot or null.
  `SBMQ_ASSERT_NOW(a_free_top_range, 1'b1, free_top <= NIL, "free top out of range")

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the shared-buffer multi-queue with its own queue predictor.
module tb;
  import sbmq_pkg::*;

  localparam int SLOTS      = 16;
  localparam int QUEUES     = 4;
  localparam int NIL        = SLOTS;
  localparam int MAX_GAP    = 40;
  localparam int IDLE_LIMIT = 500;
  localparam int DRAIN_WAIT = 4;
  localparam int SEGMENTS   = 8;
  localparam int SEG_ITEMS  = 244;

  // Predictor of the slot store: the free stack, the per-queue chains and
  // the results that accepted requests are owed, oldest first.
  class queue_scoreboard;
    logic [DataW-1:0] slot_val [SLOTS];
    int               slot_next [SLOTS];
    int               head [QUEUES];
    int               tail [QUEUES];
    int               free_top;
    result_t          owed_results [$];
    int               n_checked;
    int               n_overflow;
    int               n_underflow;
    int               n_errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        slot_val[i]  = '0;
        slot_next[i] = i + 1;
      end
      for (int i = 0; i < QUEUES; i++) begin
        head[i] = NIL;
        tail[i] = NIL;
      end
      free_top    = 0;
      n_checked   = 0;
      n_overflow  = 0;
      n_underflow = 0;
      n_errors    = 0;
    endfunction

    // Apply one accepted request to the shadow state and queue its result.
    function void take_request(request_t r);
      result_t exp;
      int      q;
      int      s;
      bit      exists;
      exp             = '0;
      exp.status      = ST_OK;
      exp.queue_empty = 1'b1;
      q               = r.queue_select;
      exists          = q < QUEUES;
      if (r.command == CMD_ENQ) begin
        if (!exists || free_top >= SLOTS) begin
          exp.status = ST_OVERFLOW;
        end else begin
          s        = free_top;
          free_top = slot_next[s];
          if (head[q] >= SLOTS) begin
            head[q] = s;
          end else if (tail[q] < SLOTS) begin
            slot_next[tail[q]] = s;
          end
          slot_next[s] = NIL;
          tail[q]      = s;
          slot_val[s]  = r.item_value;
        end
      end else begin
        if (!exists || head[q] >= SLOTS) begin
          exp.status = ST_UNDERFLOW;
        end else begin
          s                 = head[q];
          exp.removed_value = slot_val[s];
          head[q]           = slot_next[s];
          if (head[q] >= SLOTS) begin
            head[q] = NIL;
            tail[q] = NIL;
          end
          slot_next[s] = free_top;
          free_top     = s;
        end
      end
      if (exists && head[q] < SLOTS) begin
        exp.front_value = slot_val[head[q]];
        exp.queue_empty = 1'b0;
      end
      if (exp.status == ST_OVERFLOW) n_overflow++;
      if (exp.status == ST_UNDERFLOW) n_underflow++;
      owed_results.push_back(exp);
    endfunction

    function void compare_field(string name, logic [DataW-1:0] exp, logic [DataW-1:0] got);
      if (exp !== got) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp, got);
        n_errors++;
      end
    endfunction

    // Compare a result with the oldest owed one.
    function void match_result(result_t got);
      result_t exp;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, got);
        n_errors++;
        return;
      end
      exp = owed_results.pop_front();
      compare_field("status", DataW'(exp.status), DataW'(got.status));
      compare_field("removed_value", exp.removed_value, got.removed_value);
      compare_field("front_value", exp.front_value, got.front_value);
      compare_field("queue_empty", DataW'(exp.queue_empty), DataW'(got.queue_empty));
      n_checked++;
    endfunction
  endclass

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  request_t request;
  logic     done;
  result_t  result;

  queue_scoreboard sb;
  int              n_sent;
  int              idle_cycles;

  shared_buffer_multi_queue #(
    .SLOTS (SLOTS),
    .QUEUES(QUEUES)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sample both sides at the edge. Check the result first: it belongs to an
  // older request than the one transferring at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.match_result(result);
      if (start && !busy) sb.take_request(request);
    end
  end

  // Watchdog: count cycles with no transfer on either side.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time,
               sb.owed_results.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Hold one request on the port until busy lets it transfer.
  task automatic issue(input logic cmd, input logic [QselW-1:0] qsel,
                       input logic [DataW-1:0] val);
    request_t r;
    r.command      = cmd;
    r.queue_select = qsel;
    r.item_value   = val;
    start   <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    n_sent++;
  endtask

  // Drop start for a random gap; pct is the chance of each further idle cycle.
  task automatic pause(input int pct);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Lean on the extremes now and then, otherwise any 32-bit value.
  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int idle_pct [4] = '{0, 79, 9, 0};
    int enq_pct [SEGMENTS] = '{50, 80, 20, 65, 35, 90, 10, 50};
    int favored;
    logic cmd;
    logic [QselW-1:0] qsel;

    sb          = new();
    n_sent      = 0;
    rst     <= 1'b1;
    start   <= 1'b0;
    request <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: underflow on empty queues, extreme values in every queue,
    // fill the store, overflow on a full store, then drain one per queue.
    issue(CMD_DEQ, 2'd0, 32'h1234_5678);
    issue(CMD_DEQ, 2'd3, 32'h0);
    issue(CMD_ENQ, 2'd0, 32'h7FFF_FFFF);
    issue(CMD_ENQ, 2'd1, 32'h8000_0000);
    issue(CMD_ENQ, 2'd2, 32'h0000_0000);
    issue(CMD_ENQ, 2'd3, 32'hFFFF_FFFF);
    for (int i = 0; i < SLOTS - 4; i++) begin
      issue(CMD_ENQ, QselW'(i), (i % 2) ? 32'hAAAA_AAAA : 32'h5555_5555);
    end
    issue(CMD_ENQ, 2'd2, 32'hDEAD_BEEF);
    for (int i = 0; i < QUEUES; i++) begin
      issue(CMD_DEQ, QselW'(i), $urandom);
    end

    // Random: segments alternate enqueue-heavy and dequeue-heavy mixes so the
    // store keeps swinging between full and empty, with a favored queue to
    // build long chains, and cycle through the sender idling modes.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      favored = $urandom_range(QUEUES - 1);
      for (int i = 0; i < SEG_ITEMS; i++) begin
        cmd  = ($urandom_range(99) < enq_pct[seg]) ? CMD_ENQ : CMD_DEQ;
        qsel = ($urandom_range(2) == 0) ? QselW'(favored) : QselW'($urandom_range(3));
        issue(cmd, qsel, pick_value());
        pause(idle_pct[seg % 4]);
      end
    end
    start <= 1'b0;

    // Drain: wait for every owed result, then keep watching for strays.
    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.owed_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.owed_results.size());
      sb.n_errors++;
    end

    $display("Ran %0d requests over %0d queues sharing %0d slots; %0d results checked.",
             n_sent, QUEUES, SLOTS, sb.n_checked);
    $display("Store-full rejects: %0d, empty-queue rejects: %0d, mismatches: %0d.",
             sb.n_overflow, sb.n_underflow, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl
rtl/sbmq_pkg.sv
rtl/shared_buffer_multi_queue.sv
tb/sv/tb.sv
